[rtl/blsl_pkg.sv]
package blsl_pkg;

  localparam int GRID_POINTS = 11;
  localparam int VALUE_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int MAX_INDEX   = GRID_POINTS - 1;
  localparam int IDX_W       = $clog2(GRID_POINTS);
  localparam int COORD_W     = IDX_W + FRAC_BITS;

  localparam int IN_W        = 16;
  localparam int ENTRY_IDX_W = 4;
  localparam int ORG_W       = 16;
  localparam int SCALE_W     = 24;
  localparam int SCALE_FRAC  = 16;
  localparam int CFG_W       = 24;
  localparam int REG_IDX_W   = 2;
  localparam int DIFF_W      = IN_W + 1;
  localparam int PROD_W      = DIFF_W + SCALE_W + 1;

  localparam int NUM_BANKS   = 4;
  localparam int BANK_SIDE   = (GRID_POINTS + 1) / 2;
  localparam int BANK_DEPTH  = BANK_SIDE * BANK_SIDE;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);

  localparam int BLEND_W     = VALUE_WIDTH + FRAC_BITS + 1;
  localparam int SUM_W       = VALUE_WIDTH + 2 * FRAC_BITS + 1;

  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_AW      = $clog2(OUT_DEPTH);

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_WRITE  = 1'b1
  } cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_X_ORIGIN = 2'd0,
    REG_X_SCALE  = 2'd1,
    REG_Y_ORIGIN = 2'd2,
    REG_Y_SCALE  = 2'd3
  } reg_idx_t;

  // lookups: neighbor indices and fractions; writes: row in yi, column in xi
  typedef struct packed {
    logic                   write;
    logic                   wr_ok;
    logic [IDX_W-1:0]       xi;
    logic [IDX_W-1:0]       xj;
    logic [IDX_W-1:0]       yi;
    logic [IDX_W-1:0]       yj;
    logic [FRAC_BITS-1:0]   fx;
    logic [FRAC_BITS-1:0]   fy;
    logic [VALUE_WIDTH-1:0] value;
  } task_t;

endpackage

[rtl/blsl_front.sv]
module blsl_front import blsl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    push,
  output logic                    full,
  input  logic                    command,
  input  logic signed [IN_W-1:0]  x,
  input  logic signed [IN_W-1:0]  y,
  input  logic [ENTRY_IDX_W-1:0]  entry_row,
  input  logic [ENTRY_IDX_W-1:0]  entry_col,
  input  logic [VALUE_WIDTH-1:0]  entry_value,
  output task_t                   q_task,
  output logic                    q_push,
  input  logic                    q_full
);

  logic [ORG_W-1:0]   x_origin;
  logic [SCALE_W-1:0] x_scale;
  logic [ORG_W-1:0]   y_origin;
  logic [SCALE_W-1:0] y_scale;

  logic                     p_valid;
  logic                     p_write;
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic [ENTRY_IDX_W-1:0]   p_row;
  logic [ENTRY_IDX_W-1:0]   p_col;
  logic [VALUE_WIDTH-1:0]   p_value;

  logic                     p_ready;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [PROD_W-1:0] px_next;
  logic signed [PROD_W-1:0] py_next;
  logic [COORD_W-1:0]       cx;
  logic [COORD_W-1:0]       cy;
  logic [IDX_W-1:0]         xi;
  logic [IDX_W-1:0]         yi;

  function automatic logic [COORD_W-1:0] to_coord(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] hi;
    logic [COORD_W-1:0]       c;
    hi = $signed(PROD_W'(MAX_INDEX << SCALE_FRAC));
    if (p < 0) begin
      c = '0;
    end else if (p > hi) begin
      c = COORD_W'(MAX_INDEX << FRAC_BITS);
    end else begin
      c = p[SCALE_FRAC-FRAC_BITS +: COORD_W];
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= '0;
      x_scale  <= '0;
      y_origin <= '0;
      y_scale  <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_X_ORIGIN: x_origin <= cfg_data[ORG_W-1:0];
        REG_X_SCALE:  x_scale  <= cfg_data[SCALE_W-1:0];
        REG_Y_ORIGIN: y_origin <= cfg_data[ORG_W-1:0];
        REG_Y_SCALE:  y_scale  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign dx      = {x[IN_W-1], x} - {x_origin[ORG_W-1], x_origin};
  assign dy      = {y[IN_W-1], y} - {y_origin[ORG_W-1], y_origin};
  assign px_next = dx * $signed({1'b0, x_scale});
  assign py_next = dy * $signed({1'b0, y_scale});

  assign p_ready = !p_valid || !q_full;
  assign full    = !p_ready;
  assign q_push  = p_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && push) begin
      p_write <= (command == CMD_WRITE);
      px      <= px_next;
      py      <= py_next;
      p_row   <= entry_row;
      p_col   <= entry_col;
      p_value <= entry_value;
    end
  end

  assign cx = to_coord(px);
  assign cy = to_coord(py);
  assign xi = cx[COORD_W-1:FRAC_BITS];
  assign yi = cy[COORD_W-1:FRAC_BITS];

  always_comb begin
    q_task       = '0;
    q_task.write = p_write;
    q_task.value = p_value;
    if (p_write) begin
      q_task.wr_ok = (p_row <= ENTRY_IDX_W'(MAX_INDEX)) && (p_col <= ENTRY_IDX_W'(MAX_INDEX));
      q_task.yi    = IDX_W'(p_row);
      q_task.xi    = IDX_W'(p_col);
    end else begin
      q_task.xi = xi;
      q_task.yi = yi;
      q_task.xj = (xi == IDX_W'(MAX_INDEX)) ? xi : xi + IDX_W'(1);
      q_task.yj = (yi == IDX_W'(MAX_INDEX)) ? yi : yi + IDX_W'(1);
      q_task.fx = cx[FRAC_BITS-1:0];
      q_task.fy = cy[FRAC_BITS-1:0];
    end
  end

endmodule

[rtl/blsl_queue.sv]
module blsl_queue import blsl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  task_t push_task,
  output logic  full,
  input  logic  pop,
  output task_t head,
  output logic  empty
);

  task_t           slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_task;
    end
  end

endmodule

[rtl/blsl_back.sv]
module blsl_back import blsl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  task_t                         head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [VALUE_WIDTH-1:0] surface_value
);

  localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS+1)'(1 << FRAC_BITS);

  function automatic logic [BANK_AW-1:0] bank_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return BANK_AW'((r >> 1) * BANK_SIDE + (c >> 1));
  endfunction

  logic [VALUE_WIDTH-1:0] bank [NUM_BANKS][BANK_DEPTH];
  logic [VALUE_WIDTH-1:0] rd   [NUM_BANKS];
  logic [BANK_AW-1:0]     raddr [NUM_BANKS];
  logic [BANK_AW-1:0]     waddr;
  logic [1:0]             wbank;

  logic [OUT_AW:0] in_use;
  logic            lookup;

  logic                 d_valid;
  logic [FRAC_BITS-1:0] d_fx;
  logic [FRAC_BITS-1:0] d_fy;
  logic                 d_yi0, d_yj0, d_xi0, d_xj0;

  logic                      e_valid;
  logic signed [BLEND_W-1:0] e_r0;
  logic signed [BLEND_W-1:0] e_r1;
  logic [FRAC_BITS-1:0]      e_fy;

  logic [FRAC_BITS:0]        wx0;
  logic [FRAC_BITS:0]        wy0;
  logic signed [BLEND_W:0]   r0_sum;
  logic signed [BLEND_W:0]   r1_sum;
  logic signed [SUM_W-1:0]   s;

  logic [VALUE_WIDTH-1:0] o_mem [OUT_DEPTH];
  logic [OUT_AW-1:0]      o_wptr;
  logic [OUT_AW-1:0]      o_rptr;
  logic [OUT_AW:0]        o_count;
  logic                   o_pop;

  // reserve an output slot for every lookup in flight
  assign in_use = o_count + (OUT_AW+1)'(d_valid) + (OUT_AW+1)'(e_valid);
  assign q_pop  = !q_empty && (head.write || (in_use < (OUT_AW+1)'(OUT_DEPTH)));
  assign lookup = q_pop && !head.write;

  always_comb begin
    logic [1:0]       bi;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bi = 2'(b);
      r  = (head.yi[0] == bi[1]) ? head.yi : head.yj;
      c  = (head.xi[0] == bi[0]) ? head.xi : head.xj;
      raddr[b] = bank_addr(r, c);
    end
  end

  assign waddr = bank_addr(head.yi, head.xi);
  assign wbank = {head.yi[0], head.xi[0]};

  always_ff @(posedge clk) begin
    if (q_pop && head.write && head.wr_ok) begin
      bank[wbank][waddr] <= head.value;
    end
    if (lookup) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        rd[b] <= bank[b][raddr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      d_valid <= lookup;
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      d_fx  <= head.fx;
      d_fy  <= head.fy;
      d_yi0 <= head.yi[0];
      d_yj0 <= head.yj[0];
      d_xi0 <= head.xi[0];
      d_xj0 <= head.xj[0];
    end
  end

  assign wx0    = FRAC_ONE - {1'b0, d_fx};
  assign r0_sum = $signed({1'b0, wx0}) * $signed(rd[{d_yi0, d_xi0}])
                + $signed({2'b0, d_fx}) * $signed(rd[{d_yi0, d_xj0}]);
  assign r1_sum = $signed({1'b0, wx0}) * $signed(rd[{d_yj0, d_xi0}])
                + $signed({2'b0, d_fx}) * $signed(rd[{d_yj0, d_xj0}]);

  always_ff @(posedge clk) begin
    if (d_valid) begin
      e_r0 <= r0_sum[BLEND_W-1:0];
      e_r1 <= r1_sum[BLEND_W-1:0];
      e_fy <= d_fy;
    end
  end

  // round half up, then floor by arithmetic shift
  assign wy0 = FRAC_ONE - {1'b0, e_fy};
  assign s   = $signed({1'b0, wy0}) * e_r0 + $signed({2'b0, e_fy}) * e_r1
             + $signed(SUM_W'(1 << (2 * FRAC_BITS - 1)));

  assign o_pop         = pop && !empty;
  assign empty         = (o_count == '0);
  assign surface_value = $signed(o_mem[o_rptr]);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wptr  <= '0;
      o_rptr  <= '0;
      o_count <= '0;
    end else begin
      if (e_valid) begin
        o_wptr <= o_wptr + OUT_AW'(1);
      end
      if (o_pop) begin
        o_rptr <= o_rptr + OUT_AW'(1);
      end
      if (e_valid && !o_pop) begin
        o_count <= o_count + (OUT_AW+1)'(1);
      end else if (o_pop && !e_valid) begin
        o_count <= o_count - (OUT_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_valid) begin
      o_mem[o_wptr] <= s[2*FRAC_BITS +: VALUE_WIDTH];
    end
  end

endmodule

[rtl/bilinear_surface_lookup_unit.sv]
// Bilinear surface lookup over an 11x11 grid of signed 16-bit values.
// Input channel: push/full. command selects a lookup at (x, y) or a write
// of entry_value to grid (entry_row, entry_col); out-of-grid writes drop.
// Result channel: empty/pop. One surface_value per lookup, in order;
// writes give no result.
// Config: cfg_write/cfg_index/cfg_data load x_origin, x_scale, y_origin,
// y_scale (scales unsigned Q8.16), taken in the same cycle; write only
// while the block is idle.
// Path: front register, command queue, bank reads, blend register, output
// queue. Throughput: one transaction per cycle while results are popped,
// set by the four-bank grid memory that reads all four neighbors at once.
// Grid entries must be written before they are looked up.
// Reset (rst, synchronous): config registers and valid flags cleared to 0,
// queues emptied; the grid contents are kept and stay undefined until written.
// Receiver stall: results collect in a four-entry output queue, then the
// back end holds items in the command queue and full rises once it fills.
module bilinear_surface_lookup_unit import blsl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [REG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic                          command,
  input  logic signed [IN_W-1:0]        x,
  input  logic signed [IN_W-1:0]        y,
  input  logic [ENTRY_IDX_W-1:0]        entry_row,
  input  logic [ENTRY_IDX_W-1:0]        entry_col,
  input  logic signed [VALUE_WIDTH-1:0] entry_value,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [VALUE_WIDTH-1:0] surface_value
);

  task_t q_in;
  task_t q_head;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;

  blsl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .command     (command),
    .x           (x),
    .y           (y),
    .entry_row   (entry_row),
    .entry_col   (entry_col),
    .entry_value (entry_value),
    .q_task      (q_in),
    .q_push      (q_push),
    .q_full      (q_full)
  );

  blsl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_task (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  blsl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .surface_value (surface_value)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command queue read while empty");

  a_full_cause: assert property (@(posedge clk) disable iff (rst) full |-> q_full)
    else $error("input stalled without command queue backpressure");

endmodule
